// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge of clock, quiet while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every rising edge of clock, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/ukf_pkg.sv =====
package ukf_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OCC_W = 5;
   localparam int WORD_W = 32;
   localparam int STAT_W = 3;

   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   localparam logic [STAT_W-1:0] ST_ENQ   = 3'd0;
   localparam logic [STAT_W-1:0] ST_DUP   = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
   localparam logic [STAT_W-1:0] ST_DEQ   = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // item taken: latch it and run the key compare
      logic commit;   // decide, update the queue and fill the result register
   } ctrl_cmd_type;

endpackage

// ===== rtl/ukf_ifs.sv =====
interface ukf_req_if;
   import ukf_pkg::*;

   logic valid;
   logic ready;
   logic kind;
   logic signed [WORD_W-1:0] entry_key;
   logic signed [WORD_W-1:0] entry_data;

   modport source (output valid, kind, entry_key, entry_data, input ready);
   modport sink (input valid, kind, entry_key, entry_data, output ready);
endinterface

interface ukf_rsp_if;
   import ukf_pkg::*;

   logic valid;
   logic ready;
   logic [STAT_W-1:0] status;
   logic signed [WORD_W-1:0] removed_key;
   logic signed [WORD_W-1:0] removed_data;
   logic is_empty;
   logic [OCC_W-1:0] occupancy;

   modport source (output valid, status, removed_key, removed_data, is_empty, occupancy,
                   input ready);
   modport sink (input valid, status, removed_key, removed_data, is_empty, occupancy,
                 output ready);
endinterface

// ===== rtl/unique_key_fifo.sv =====
// Queue of up to 16 key/data pairs that refuses an enqueue whose key is
// already held (status 1, checked before full), an enqueue into a full
// queue (status 2) and a dequeue from an empty one (status 4); every item
// gives exactly one result with the removed pair on a dequeue, the empty
// flag and the occupancy after the operation. An item is first latched
// and its key compared against every held entry in parallel, then the
// update is committed into the result register. The next item is
// taken once the commit is done, and the result register holds one
// finished result while the next item is worked on; a commit waits only
// while that register is full and not being drained.
module unique_key_fifo (
   input logic clock,
   input logic reset,
   ukf_req_if.sink   req_ch,
   ukf_rsp_if.source rsp_ch
);
   import ukf_pkg::*;

   ctrl_cmd_type cmd;

   ukf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   ukf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req_ch.kind),
      .req_key          (req_ch.entry_key),
      .req_data         (req_ch.entry_data),
      .rsp_status       (rsp_ch.status),
      .rsp_removed_key  (rsp_ch.removed_key),
      .rsp_removed_data (rsp_ch.removed_data),
      .rsp_is_empty     (rsp_ch.is_empty),
      .rsp_occupancy    (rsp_ch.occupancy)
   );

endmodule

// ===== rtl/ukf_ctrl.sv =====
module ukf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output ukf_pkg::ctrl_cmd_type cmd
);
   import ukf_pkg::*;

   localparam logic [0:0] S_IDLE   = 1'b0;
   localparam logic [0:0] S_COMMIT = 1'b1;

   logic [0:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   // result register can take a new item when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/ukf_datapath.sv =====
module ukf_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  ukf_pkg::ctrl_cmd_type            cmd,
   input  logic                             req_kind,
   input  logic signed [ukf_pkg::WORD_W-1:0] req_key,
   input  logic signed [ukf_pkg::WORD_W-1:0] req_data,
   output logic [ukf_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [ukf_pkg::WORD_W-1:0] rsp_removed_key,
   output logic signed [ukf_pkg::WORD_W-1:0] rsp_removed_data,
   output logic                             rsp_is_empty,
   output logic [ukf_pkg::OCC_W-1:0]        rsp_occupancy
);
   import ukf_pkg::*;

   word_type key_store [DEPTH];
   word_type data_store [DEPTH];

   idx_type  head_ff, head_in;
   idx_type  tail_ff, tail_in;
   cnt_type  count_ff, count_in;

   logic     kind_ff;
   word_type key_ff;
   word_type data_ff;
   logic [DEPTH-1:0] held;
   logic [DEPTH-1:0] match_ff;
   word_type rd_key_ff;
   word_type rd_data_ff;

   logic [STAT_W-1:0] status_in, status_ff;
   word_type rkey_in, rkey_ff;
   word_type rdata_in, rdata_ff;
   logic     empty_ff;
   logic [OCC_W-1:0] occ_ff;
   logic     do_write;

   function automatic idx_type next_slot(input idx_type slot);
      return (slot == idx_type'(DEPTH - 1)) ? '0 : idx_type'(slot + 1'b1);
   endfunction

   // an entry is held when its distance from head is below the count
   for (genvar g = 0; g < DEPTH; g++) begin : g_held
      localparam logic [CNT_W:0] G_IDX = (CNT_W + 1)'(g);
      logic [CNT_W:0] hd;
      logic [CNT_W:0] span;
      assign hd = (CNT_W + 1)'(head_ff);
      assign span = (G_IDX >= hd) ? G_IDX - hd : G_IDX + (CNT_W + 1)'(DEPTH) - hd;
      assign held[g] = span < (CNT_W + 1)'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         key_ff <= req_key;
         data_ff <= req_data;
         for (int i = 0; i < DEPTH; i++) begin
            match_ff[i] <= held[i] && (key_store[i] == word_type'(req_key));
         end
      end
      // oldest entry, read ahead so it is ready at commit
      rd_key_ff <= key_store[head_ff];
      rd_data_ff <= data_store[head_ff];
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      rkey_in = '0;
      rdata_in = '0;
      do_write = 1'b0;
      if (kind_ff == KIND_ENQ) begin
         if (|match_ff) begin
            status_in = ST_DUP;
         end else if (count_ff == cnt_type'(DEPTH)) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_ENQ;
            do_write = 1'b1;
            tail_in = next_slot(tail_ff);
            count_in = cnt_type'(count_ff + 1'b1);
         end
      end else begin
         if (count_ff == '0) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_DEQ;
            rkey_in = rd_key_ff;
            rdata_in = rd_data_ff;
            head_in = next_slot(head_ff);
            count_in = cnt_type'(count_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_write) begin
         key_store[tail_ff] <= key_ff;
         data_store[tail_ff] <= data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         rkey_ff <= rkey_in;
         rdata_ff <= rdata_in;
         empty_ff <= (count_in == '0);
         occ_ff <= OCC_W'(count_in);
      end
   end

   assign rsp_status = status_ff;
   assign rsp_removed_key = $signed(rkey_ff);
   assign rsp_removed_data = $signed(rdata_ff);
   assign rsp_is_empty = empty_ff;
   assign rsp_occupancy = occ_ff;

endmodule

// ===== rtl/ukf_checker.sv =====
`include "assert_macros.svh"

module ukf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ukf_pkg::STAT_W-1:0]       rsp_status,
   input logic signed [ukf_pkg::WORD_W-1:0] rsp_removed_key,
   input logic signed [ukf_pkg::WORD_W-1:0] rsp_removed_data,
   input logic                             rsp_is_empty,
   input logic [ukf_pkg::OCC_W-1:0]        rsp_occupancy
);
   import ukf_pkg::*;

   // a stalled result keeps its place and its status
   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status), "result dropped or changed while stalled")

   // one item at a time: no second item right after one is taken
   `ASSERT_CLK(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "item taken while previous still in work")

   `ASSERT_CLK(a_occ_bound, rsp_valid |-> (rsp_occupancy <= OCC_W'(DEPTH)) && (rsp_is_empty == (rsp_occupancy == '0)), "occupancy out of range or disagrees with empty flag")

   `ASSERT_CLK(a_removed_zero, rsp_valid && (rsp_status != ST_DEQ) |-> (rsp_removed_key == '0) && (rsp_removed_data == '0), "removed pair nonzero on a non-dequeue result")

endmodule

bind unique_key_fifo ukf_checker u_ukf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_removed_key  (rsp_ch.removed_key),
   .rsp_removed_data (rsp_ch.removed_data),
   .rsp_is_empty     (rsp_ch.is_empty),
   .rsp_occupancy    (rsp_ch.occupancy)
);
